>>> src/dtvp_pkg.sv
// ----------------------------------------------------------------------------
// Top-view projection package
// Shared field widths, request codes, register indexes and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package dtvp_pkg;

  localparam int unsigned DEPTH_W = 16;
  localparam int unsigned ROW_W   = 10;
  localparam int unsigned COL_W   = 10;
  localparam int unsigned RBIN_W  = 7;
  localparam int unsigned CIDX_W  = 1;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  localparam logic [CIDX_W-1:0] REG_SHALLOW = 1'b0;
  localparam logic [CIDX_W-1:0] REG_DEEP    = 1'b1;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_MUL   = 7'b0000100,
    ST_DIV   = 7'b0001000,
    ST_ADDR  = 7'b0010000,
    ST_RD    = 7'b0100000,
    ST_WB    = 7'b1000000
  } state_e;

endpackage

`default_nettype wire

>>> src/dtvp_ram.sv
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// Synchronous write, registered read with a read enable that holds the data.
// ----------------------------------------------------------------------------
`default_nettype none

module dtvp_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 64000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> src/depth_image_top_view_projection_unit.sv
// ----------------------------------------------------------------------------
// Depth image top-view projection unit
// Bins depth pixels per column and keeps the largest row in each bin; read
// requests return one entry and clear it.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake                 | Payload
//  ---------+-----------+---------------------------+----------------------------
//  in       | in        | in_valid_i / in_stall_o   | req_type, pixel_row,
//           |           |                           | column_index, depth_value,
//           |           |                           | read_bin
//  out      | out       | out_valid_o / out_stall_i | max_row
//  cfg      | in        | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// One request is processed at a time. A pixel update runs a multiply, the
// bit-serial bin divider (NUM_W = clog2(DEPTH_BINS) + 16 bits), an address
// step, a store read and a write-back; a read skips the divider. A dropped
// pixel is accepted and not stored. After reset the store is cleared one entry
// per cycle (MAX_COLUMNS * DEPTH_BINS entries, 64000 by default) with requests
// stalled. A full output register stalls a read in its last step only.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_image_top_view_projection_unit
  import dtvp_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS = 640,
  parameter int unsigned DEPTH_BINS  = 100,
  parameter int unsigned MAX_ROWS    = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               req_type_i,
  input  wire logic [ROW_W-1:0]   pixel_row_i,
  input  wire logic [COL_W-1:0]   column_index_i,
  input  wire logic [DEPTH_W-1:0] depth_value_i,
  input  wire logic [RBIN_W-1:0]  read_bin_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic      [ROW_W-1:0]   max_row_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CIDX_W-1:0]  cfg_idx_i,
  input  wire logic [DEPTH_W-1:0] cfg_wdata_i
);

  localparam int unsigned STORE_DEPTH = MAX_COLUMNS * DEPTH_BINS;
  localparam int unsigned AW          = $clog2(STORE_DEPTH);
  localparam int unsigned BW          = $clog2(DEPTH_BINS);
  localparam int unsigned NUM_W       = BW + DEPTH_W;
  localparam int unsigned DCW         = $clog2(NUM_W + 1);

  state_e state_q, state_d;

  logic [DEPTH_W-1:0] shallow_q, deep_q;
  logic [AW-1:0]      clr_addr_q;
  logic [DCW-1:0]     div_cnt_q;
  logic               out_valid_q;
  logic [ROW_W-1:0]   max_row_q;

  // Request payload and datapath registers.
  logic               req_q;
  logic               ok_q;
  logic [ROW_W-1:0]   row_q;
  logic [COL_W-1:0]   col_q;
  logic [RBIN_W-1:0]  rbin_q;
  logic [DEPTH_W-1:0] diff_q;
  logic [DEPTH_W-1:0] den_q;
  logic [NUM_W-1:0]   num_q;
  logic [DEPTH_W-1:0] rem_q;
  logic [AW-1:0]      base_q;
  logic [AW-1:0]      addr_q;

  logic               accept;
  logic               pix_ok, rd_ok;
  logic [DEPTH_W:0]   rem_sh;
  logic               rem_ge;
  logic [BW-1:0]      pix_bin, bin;
  logic               out_free;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr;
  logic [ROW_W-1:0]   ram_wdata, ram_rdata;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign max_row_o   = max_row_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign pix_ok = (depth_value_i > shallow_q) && (deep_q > shallow_q) &&
                  (32'(column_index_i) < MAX_COLUMNS) && (32'(pixel_row_i) < MAX_ROWS);
  assign rd_ok  = (32'(column_index_i) < MAX_COLUMNS) && (32'(read_bin_i) < DEPTH_BINS);

  // Restoring division step: the quotient bits shift into num_q from the right.
  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, den_q});

  // Ceiling of the quotient, saturated at the top bin.
  always_comb begin
    if (num_q >= NUM_W'(DEPTH_BINS - 1)) begin
      pix_bin = BW'(DEPTH_BINS - 1);
    end else begin
      pix_bin = BW'(num_q) + BW'(rem_q != '0);
    end
    bin = (req_q == REQ_READ) ? BW'(rbin_q) : pix_bin;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_addr_q == AW'(STORE_DEPTH - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (req_type_i == REQ_READ || pix_ok) state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = (req_q == REQ_READ) ? ST_ADDR : ST_DIV;
      end
      ST_DIV: begin
        if (div_cnt_q == DCW'(NUM_W - 1)) state_d = ST_ADDR;
      end
      ST_ADDR: state_d = ST_RD;
      ST_RD:   state_d = ST_WB;
      ST_WB: begin
        if (req_q == REQ_PIXEL || out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      shallow_q   <= '0;
      deep_q      <= '1;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_addr_q <= clr_addr_q + AW'(1);
      if (state_q == ST_DIV) begin
        div_cnt_q <= div_cnt_q + DCW'(1);
      end else begin
        div_cnt_q <= '0;
      end
      if (state_q == ST_WB && req_q == REQ_READ && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SHALLOW: shallow_q <= cfg_wdata_i;
          REG_DEEP:    deep_q    <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= req_type_i;
      ok_q   <= rd_ok;
      row_q  <= pixel_row_i;
      col_q  <= column_index_i;
      rbin_q <= read_bin_i;
      diff_q <= depth_value_i - shallow_q;
      den_q  <= deep_q - shallow_q;
    end
    if (state_q == ST_MUL) begin
      num_q  <= NUM_W'(DEPTH_BINS - 1) * NUM_W'(diff_q);
      rem_q  <= '0;
      base_q <= AW'(col_q) * AW'(DEPTH_BINS);
    end else if (state_q == ST_DIV) begin
      num_q <= {num_q[NUM_W-2:0], rem_ge};
      rem_q <= rem_ge ? DEPTH_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEPTH_W-1:0];
    end
    if (state_q == ST_ADDR) addr_q <= base_q + AW'(bin);
    if (state_q == ST_WB && req_q == REQ_READ && out_free) begin
      max_row_q <= ok_q ? ram_rdata : '0;
    end
  end

  // Write port: zero sweep after reset, then the write-back of the current request.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = '0;
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
    end else if (state_q == ST_WB) begin
      if (req_q == REQ_READ) begin
        ram_we = ok_q;
      end else begin
        ram_we    = (row_q > ram_rdata);
        ram_wdata = row_q;
      end
    end
  end

  assign ram_re = (state_q == ST_RD);

  dtvp_ram #(
    .WIDTH (ROW_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire
